FILE: rtl/stts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted time-slot table package
// Request and response transaction types, request and status codes, and the
// key range limits used by the table's controller.
// ----------------------------------------------------------------------------
package stts_pkg;

    localparam int KEY_W     = 14;   // month(4) day(5) hour(5)
    localparam int TAG_W     = 16;   // tag field width on the ports

    localparam logic [3:0] MONTH_MIN = 4'd1;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] DAY_MIN   = 5'd1;
    localparam logic [4:0] DAY_MAX   = 5'd31;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LIST   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MONTH = 3'd1;
    localparam logic [2:0] ST_BAD_HOUR  = 3'd2;
    localparam logic [2:0] ST_BAD_DAY   = 3'd3;
    localparam logic [2:0] ST_TAKEN     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [3:0]       key_month;
        logic [4:0]       key_day;
        logic [4:0]       key_hour;
        logic [TAG_W-1:0] entry_tag;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             entry_valid;
        logic [3:0]       out_month;
        logic [4:0]       out_day;
        logic [4:0]       out_hour;
        logic [TAG_W-1:0] out_tag;
        logic             last;
    } rsp_t;

endpackage

FILE: rtl/sorted_time_slot_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted time-slot table
// Table of (month, day, hour) keyed entries with tags, kept in ascending key
// order in a rotating chain of cells; supports insert, delete and list.
// ----------------------------------------------------------------------------
// Each insert or delete that passes the key range checks, and each list of
// a non-empty table, rotates the whole chain of CAPACITY cells exactly once,
// one cell per cycle unless a list holds it, so the rotation length is set by
// the chain depth: the controller sees one entry a cycle at the head and
// writes the rewritten stream back at the tail. After its rotation an insert
// or delete loads its single status response. A new request is taken only
// when the block is idle and its response register is empty, which is the
// cycle after the response leaves, so the block takes no new request while
// it is still busy with the last one. A request rejected by a range check
// and a list of an empty table load their response at the accepting edge;
// an unknown request code is dropped there with no response. A list
// delivers one response transaction per entry in key order and holds the
// rotation while the response register is occupied, so a slow receiver
// stretches it.
// ----------------------------------------------------------------------------
module sorted_time_slot_table_unit #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  stts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output stts_pkg::rsp_t rsp
);

    import stts_pkg::*;

    // Only the tag bits that survive on the ports are stored.
    localparam int STORE_TAG = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int EW        = KEY_W + STORE_TAG;

    logic [EW-1:0] cell_q [CAPACITY];
    logic [EW-1:0] tail;
    logic          shift_en;

    // Chain of cells: every shift moves each entry one cell toward the head;
    // the controller feeds the tail.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_tail
            stts_cell #(.W(EW)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tail),
                .q        (cell_q[i])
            );
        end
        else
        begin : g_mid
            stts_cell #(.W(EW)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[i+1]),
                .q        (cell_q[i])
            );
        end
    end

    // Controller: range checks, stream rewrite, response register.
    stts_ctrl #(
        .CAPACITY  (CAPACITY),
        .STORE_TAG (STORE_TAG)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .head      (cell_q[0]),
        .head2     (cell_q[1]),
        .tail      (tail),
        .shift_en  (shift_en)
    );

endmodule

FILE: rtl/stts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table cell
// Holds one table entry; on a shift it takes the entry of its neighbor
// toward the tail of the chain.
// ----------------------------------------------------------------------------
module stts_cell #(
    parameter int W = 30
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

FILE: rtl/stts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table controller
// Accepts requests, checks key ranges, and rotates the cell chain once per
// in-range insert, delete or non-empty list, rewriting the stream at the tail.
// ----------------------------------------------------------------------------
module stts_ctrl #(
    parameter int CAPACITY  = 16,
    parameter int STORE_TAG = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  stts_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output stts_pkg::rsp_t                    rsp,
    input  logic [stts_pkg::KEY_W+STORE_TAG-1:0] head,
    input  logic [stts_pkg::KEY_W+STORE_TAG-1:0] head2,
    output logic [stts_pkg::KEY_W+STORE_TAG-1:0] tail,
    output logic                              shift_en
);

    import stts_pkg::*;

    localparam int EW = KEY_W + STORE_TAG;
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_K = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_N = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_REPLY = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     op_reg, op_next;
    logic [EW-1:0]  new_reg, new_next;
    logic [EW-1:0]  hold_reg, hold_next;
    logic [IW-1:0]  k_reg, k_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           hit_reg, hit_next;
    logic [2:0]     status_reg, status_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    logic             rsp_free;
    logic             head_v;
    logic             emit;
    logic [KEY_W-1:0] head_key;
    logic [KEY_W-1:0] new_key;
    logic [CW-1:0]    k_ext;
    logic             full;
    logic [2:0]       range_st;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign k_ext     = CW'(k_reg);
    assign head_v    = k_ext < count_reg;
    assign head_key  = head[EW-1 -: KEY_W];
    assign new_key   = new_reg[EW-1 -: KEY_W];
    assign full      = count_reg == FULL_N;
    assign emit      = (op_reg == REQ_LIST) && head_v;
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;

    always_comb
    begin
        priority if (req.key_month < MONTH_MIN || req.key_month > MONTH_MAX)
            range_st = ST_BAD_MONTH;
        else if (req.key_hour > HOUR_MAX)
            range_st = ST_BAD_HOUR;
        else if (req.key_day < DAY_MIN || req.key_day > DAY_MAX)
            range_st = ST_BAD_DAY;
        else
            range_st = ST_OK;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        new_next       = new_reg;
        hold_next      = hold_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        shift_en       = 1'b0;
        tail           = head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    op_next  = req.req_type;
                    new_next = {req.key_month, req.key_day, req.key_hour,
                                req.entry_tag[STORE_TAG-1:0]};
                    k_next   = '0;
                    hit_next = 1'b0;
                    rsp_next = '0;
                    rsp_next.last = 1'b1;
                    unique case (req.req_type)
                        REQ_LIST:
                        begin
                            if (count_reg == '0)
                                rsp_valid_next = 1'b1;
                            else
                                state_next = S_SCAN;
                        end
                        REQ_INSERT, REQ_DELETE:
                        begin
                            if (range_st != ST_OK)
                            begin
                                rsp_next.status = range_st;
                                rsp_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                shift_en = !emit || rsp_free;
                if (shift_en)
                begin
                    k_next = k_reg + 1'b1;
                    unique case (op_reg)
                        REQ_LIST:
                        begin
                            if (emit)
                            begin
                                rsp_next.status      = ST_OK;
                                rsp_next.entry_valid = 1'b1;
                                rsp_next.out_month   = head[EW-1 -: 4];
                                rsp_next.out_day     = head[EW-5 -: 5];
                                rsp_next.out_hour    = head[EW-10 -: 5];
                                rsp_next.out_tag     = TAG_W'(head[STORE_TAG-1:0]);
                                rsp_next.last        = (k_ext + 1'b1) == count_reg;
                                rsp_valid_next       = 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            priority if (hit_reg && status_reg == ST_OK)
                            begin
                                // Entries behind the new one move up a slot.
                                tail      = hold_reg;
                                hold_next = head;
                            end
                            else if (hit_reg)
                            begin
                                tail = head;
                            end
                            else if (head_v && head_key == new_key)
                            begin
                                hit_next    = 1'b1;
                                status_next = ST_TAKEN;
                            end
                            else if (!full && (!head_v || head_key > new_key))
                            begin
                                tail        = new_reg;
                                hold_next   = head;
                                hit_next    = 1'b1;
                                status_next = ST_OK;
                            end
                            else
                            begin
                                tail = head;
                            end
                        end
                        default:
                        begin
                            // Delete: from the match on, pull the next entry in.
                            if (hit_reg || (head_v && head_key == new_key))
                            begin
                                tail     = head2;
                                hit_next = 1'b1;
                            end
                        end
                    endcase

                    if (k_reg == LAST_K)
                    begin
                        if (op_reg == REQ_LIST)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_REPLY;
                            if (op_reg == REQ_INSERT)
                            begin
                                if (!hit_next)
                                    status_next = ST_FULL;
                                else if (status_next == ST_OK)
                                    count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = hit_next ? ST_OK : ST_NOT_FOUND;
                                if (hit_next)
                                    count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end
            end

            default:
            begin
                if (rsp_free)
                begin
                    rsp_next        = '0;
                    rsp_next.status = status_reg;
                    rsp_next.last   = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= REQ_INSERT;
            k_reg         <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg  <= new_next;
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_N)
        else $error("entry count above capacity");

    a_shift_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> state_reg == S_SCAN)
        else $error("chain shifted outside a scan");

    a_count_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_SCAN))
        else $error("entry count changed outside a scan");

    a_entry_only_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.entry_valid) |-> op_reg == REQ_LIST)
        else $error("entry carried by a non-list response");

endmodule

FILE: tb/sv/tb_sorted_time_slot_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted time-slot table testbench
// Drives insert, delete and list requests into the table and checks every
// response against a behavioral table kept inside the testbench. Both sides
// idle at random, and the response side is held off once for a long stretch
// so that the block stalls its request side.
// ----------------------------------------------------------------------------
module tb_sorted_time_slot_table_unit;

    import stts_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------------
    localparam int CAPACITY        = 16;
    localparam int TAG_BITS        = 16;
    localparam int RANDOM_ITEMS    = 160;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RX_STALL_CYCLES = 300;   // long hold-off of the response side
    localparam int DRAIN_CYCLES    = 40;    // a full rotation plus margin
    localparam int FAULT_SHOW      = 10;    // mismatches printed in full

    // Request code with no meaning to the block; it must be dropped silently.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Where a random key comes from: a tiny pool that collides often, the
    // whole legal range, or any bit pattern at all.
    typedef enum int {KEY_POOL, KEY_SPREAD, KEY_ANY} key_mode_e;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    always #5 clk = ~clk;

    sorted_time_slot_table_unit #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Behavioral table: keys packed as {month, day, hour} so that a plain
    // unsigned compare gives the sort order month, then day, then hour.
    // ------------------------------------------------------------------------
    logic [13:0]      slot_key [CAPACITY];
    logic [TAG_W-1:0] slot_tag [CAPACITY];
    int               slot_count = 0;

    rsp_t pending_rsp[$];       // responses still owed by the block, oldest first

    int fault_cnt  = 0;
    int cycle_cnt  = 0;
    int stall_asks = 0;         // bumped by a test to request a long hold-off
    bit idle_off   = 1'b0;      // while set, neither side idles

    function automatic int find_slot(input logic [13:0] key);
        for (int i = 0; i < slot_count; i++)
            if (slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Work out the responses one accepted request causes and update the table.
    function automatic void predict_table_request(input req_t r);
        rsp_t        res;
        logic [13:0] key;
        int          pos;
        res      = '0;
        res.last = 1'b1;
        key      = {r.key_month, r.key_day, r.key_hour};
        case (r.req_type)
            REQ_LIST:
            begin
                if (slot_count == 0)
                begin
                    pending_rsp.push_back(res);     // empty table: one bare item
                end
                else
                begin
                    for (int i = 0; i < slot_count; i++)
                    begin
                        res.status      = ST_OK;
                        res.entry_valid = 1'b1;
                        res.out_month   = slot_key[i][13:10];
                        res.out_day     = slot_key[i][9:5];
                        res.out_hour    = slot_key[i][4:0];
                        res.out_tag     = slot_tag[i];
                        res.last        = (i == slot_count - 1);
                        pending_rsp.push_back(res);
                    end
                end
            end
            REQ_INSERT, REQ_DELETE:
            begin
                // Range checks run in the order month, hour, day.
                if (r.key_month < MONTH_MIN || r.key_month > MONTH_MAX)
                    res.status = ST_BAD_MONTH;
                else if (r.key_hour > HOUR_MAX)
                    res.status = ST_BAD_HOUR;
                else if (r.key_day < DAY_MIN || r.key_day > DAY_MAX)
                    res.status = ST_BAD_DAY;
                else if (r.req_type == REQ_INSERT)
                begin
                    pos = 0;
                    while (pos < slot_count && slot_key[pos] < key)
                        pos++;
                    if (pos < slot_count && slot_key[pos] == key)
                        res.status = ST_TAKEN;      // taken wins over full
                    else if (slot_count >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        for (int i = slot_count; i > pos; i--)
                        begin
                            slot_key[i] = slot_key[i-1];
                            slot_tag[i] = slot_tag[i-1];
                        end
                        slot_key[pos] = key;
                        slot_tag[pos] = r.entry_tag;
                        slot_count++;
                        res.status = ST_OK;
                    end
                end
                else
                begin
                    pos = find_slot(key);
                    if (pos < 0)
                        res.status = ST_NOT_FOUND;
                    else
                    begin
                        for (int i = pos; i + 1 < slot_count; i++)
                        begin
                            slot_key[i] = slot_key[i+1];
                            slot_tag[i] = slot_tag[i+1];
                        end
                        slot_count--;
                        res.status = ST_OK;
                    end
                end
                pending_rsp.push_back(res);
            end
            default: ;  // unused code: no response, table untouched
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input logic [1:0] kind, input logic [13:0] key,
                                      input logic [TAG_W-1:0] tag);
        req_t r;
        r.req_type  = kind;
        r.key_month = key[13:10];
        r.key_day   = key[9:5];
        r.key_hour  = key[4:0];
        r.entry_tag = tag;
        return r;
    endfunction

    function automatic logic [13:0] pick_key(input key_mode_e mode);
        case (mode)
            KEY_POOL:   return {4'($urandom_range(1, 3)), 5'($urandom_range(1, 4)),
                                5'($urandom_range(0, 3))};
            KEY_SPREAD: return {4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                                5'($urandom_range(0, 23))};
            default:    return {4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                                5'($urandom_range(0, 31))};
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until the block takes it. Entered and left
    // right after a rising edge; valid drops only when an idle gap follows, so
    // back-to-back requests keep valid high without a second assignment.
    // Handshakes are sampled at the falling edge, where everything is settled.
    task automatic send_req(input req_t r);
        int gap;
        gap = idle_off ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(negedge clk); while (!req_ready);
        predict_table_request(r);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random ready with gaps, plus the long hold-off on request
    // ------------------------------------------------------------------------
    int rx_hold    = 0;
    int stall_seen = 0;

    always @(posedge clk)
    begin
        if (stall_seen != stall_asks)
        begin
            stall_seen <= stall_asks;
            rx_hold    <= RX_STALL_CYCLES;
            rsp_ready  <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold   <= rx_hold - 1;
            rsp_ready <= 1'b0;
        end
        else if (!idle_off && $urandom_range(0, 99) < 20)
        begin
            rx_hold   <= pick_gap();
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    function automatic string rsp_text(input rsp_t x);
        return $sformatf("st=%0d vld=%0d m=%0d d=%0d h=%0d tag=%h last=%0d",
                         x.status, x.entry_valid, x.out_month, x.out_day,
                         x.out_hour, x.out_tag, x.last);
    endfunction

    task automatic log_fault(input string what);
        fault_cnt++;
        if (fault_cnt <= FAULT_SHOW)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                log_fault({"unexpected response: ", rsp_text(rsp)});
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status || rsp.entry_valid !== want.entry_valid ||
                    rsp.out_month !== want.out_month || rsp.out_day !== want.out_day ||
                    rsp.out_hour !== want.out_hour || rsp.out_tag !== want.out_tag ||
                    rsp.last !== want.last)
                    log_fault({"mismatch: expected ", rsp_text(want),
                               " got ", rsp_text(rsp)});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Range checks, their order, every request kind and the basic table moves.
    task automatic test_key_checks();
        send_req(make_req(REQ_LIST,   '0, '0));                          // empty list
        send_req(make_req(REQ_INSERT, {4'd0,  5'd0,  5'd31}, 16'h1111)); // month first
        send_req(make_req(REQ_INSERT, {4'd13, 5'd15, 5'd10}, 16'h2222));
        send_req(make_req(REQ_INSERT, {4'd15, 5'd31, 5'd31}, 16'h3333));
        send_req(make_req(REQ_INSERT, {4'd12, 5'd0,  5'd24}, 16'h4444)); // hour before day
        send_req(make_req(REQ_INSERT, {4'd1,  5'd15, 5'd31}, 16'h5555));
        send_req(make_req(REQ_INSERT, {4'd7,  5'd0,  5'd23}, 16'h6666)); // day zero
        send_req(make_req(REQ_DELETE, {4'd0,  5'd5,  5'd5},  '0));
        send_req(make_req(REQ_DELETE, {4'd5,  5'd5,  5'd24}, '0));
        send_req(make_req(REQ_DELETE, {4'd5,  5'd0,  5'd5},  '0));
        send_req(make_req(REQ_UNUSED, {4'd5,  5'd5,  5'd5},  16'h7777)); // dropped
        send_req(make_req(REQ_INSERT, {4'd1,  5'd1,  5'd0},  16'h0000)); // lowest key
        send_req(make_req(REQ_INSERT, {4'd12, 5'd31, 5'd23}, 16'hFFFF)); // highest key
        send_req(make_req(REQ_INSERT, {4'd6,  5'd15, 5'd12}, 16'hA5A5)); // lands between
        send_req(make_req(REQ_INSERT, {4'd6,  5'd15, 5'd12}, 16'h5A5A)); // slot taken
        send_req(make_req(REQ_DELETE, {4'd6,  5'd15, 5'd11}, '0));       // not found
        send_req(make_req(REQ_LIST,   '1, '1));
        send_req(make_req(REQ_DELETE, {4'd1,  5'd1,  5'd0},  '0));       // remove head
        send_req(make_req(REQ_LIST,   '0, '0));
        send_req(make_req(REQ_INSERT, {4'd8,  5'd16, 5'd16}, 16'h8001));
        send_req(make_req(REQ_DELETE, {4'd12, 5'd31, 5'd23}, '0));       // remove tail
        send_req(make_req(REQ_LIST,   '0, '0));
        send_req(make_req(REQ_UNUSED, '1, '1));
    endtask

    // Fill to capacity, then hit full, taken-on-full and a range error on full.
    task automatic test_full_table();
        logic [13:0] key;
        while (slot_count < CAPACITY)
            send_req(make_req(REQ_INSERT, pick_key(KEY_SPREAD), 16'($urandom)));
        do key = pick_key(KEY_SPREAD); while (find_slot(key) >= 0);
        send_req(make_req(REQ_INSERT, key, 16'($urandom)));
        send_req(make_req(REQ_INSERT, slot_key[$urandom_range(0, CAPACITY - 1)],
                          16'($urandom)));
        send_req(make_req(REQ_INSERT, {4'd13, 5'd1, 5'd1}, 16'($urandom)));
        send_req(make_req(REQ_LIST, '0, '0));
    endtask

    // Hold the response side off while requests keep coming: the list of a
    // full table backs up and the block must stop taking requests.
    task automatic test_back_pressure();
        stall_asks++;
        send_req(make_req(REQ_LIST, '0, '0));
        repeat (6)
            send_req(make_req($urandom_range(0, 1) ? REQ_INSERT : REQ_DELETE,
                              pick_key(KEY_POOL), 16'($urandom)));
        send_req(make_req(REQ_LIST, '0, '0));
    endtask

    // Mostly legal traffic over a small key pool so that collisions, hits and
    // a full table come up often; the rest is spread keys and pure noise.
    task automatic test_random_traffic();
        int          roll;
        int          src;
        key_mode_e   mode;
        logic [1:0]  kind;
        logic [13:0] key;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            src  = $urandom_range(0, 99);
            if (src < 60)      mode = KEY_POOL;
            else if (src < 88) mode = KEY_SPREAD;
            else               mode = KEY_ANY;
            key = pick_key(mode);
            if (roll < 42)
            begin
                kind = REQ_INSERT;
            end
            else if (roll < 70)
            begin
                kind = REQ_DELETE;
                // aim at a stored entry about half the time
                if (slot_count > 0 && $urandom_range(0, 1))
                    key = slot_key[$urandom_range(0, slot_count - 1)];
            end
            else if (roll < 86)
            begin
                kind = REQ_LIST;
            end
            else
            begin
                kind = 2'($urandom_range(0, 3));
            end
            send_req(make_req(kind, key, 16'($urandom)));
        end
    endtask

    // Empty the table in random order with no idling on either side, then
    // list the empty table and refill a little.
    task automatic test_drain();
        idle_off = 1'b1;
        while (slot_count > 0)
            send_req(make_req(REQ_DELETE, slot_key[$urandom_range(0, slot_count - 1)],
                              '0));
        send_req(make_req(REQ_LIST, '0, '0));
        repeat (4)
            send_req(make_req(REQ_INSERT, pick_key(KEY_SPREAD), 16'($urandom)));
        send_req(make_req(REQ_LIST, '0, '0));
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_checks();
        test_full_table();
        test_back_pressure();
        test_random_traffic();
        test_drain();

        // Stop offering, collect what is owed, then watch for strays.
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
